// ----- rtl/core/fmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types, codes and constants of the fast marching grid block.
// ----------------------------------------------------------------------------
package fmm_pkg;

  localparam int TIME_W = 24;
  localparam int COST_W = 16;
  localparam int SUM_W  = TIME_W + 2;
  localparam int SQ_W   = 34;

  localparam logic [TIME_W-1:0] TIME_INF = 24'hFFFFFF;
  localparam logic [TIME_W-1:0] TIME_MAX = 24'hFFFFFE;
  localparam logic [COST_W-1:0] COST_OBST = 16'hFFFF;
  localparam logic [SQ_W-1:0]   SQ_BIT0 = 34'h1_0000_0000;

  // command codes of an input word
  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_RUN   = 2'd1,
    FN_READ  = 2'd2,
    FN_BAD   = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // neighbor directions
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ITEM_RD,
    OP_ITEM_EVAL,
    OP_SWEEP_RD,
    OP_SWEEP_WR,
    OP_SRC,
    OP_NB_RD,
    OP_NB_EVAL,
    OP_TQ_RD,
    OP_TQ_ACC,
    OP_EIK_GO,
    OP_NEXT_K,
    OP_FIND_INIT,
    OP_FIND_RD,
    OP_FIND_CMP,
    OP_REM_RD,
    OP_REM_WR,
    OP_REM_END,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_CMP,
    OP_INS_PUT,
    OP_SET_TIME,
    OP_POP_RD,
    OP_POP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } fmm_cmd_t;

  typedef struct packed {
    logic run_go;
    logic sweep_last;
    logic nb_skip;
    logic q_last;
    logic eik_busy;
    logic t_inf;
    logic old_inf;
    logic t_lt_old;
    logic j_zero;
    logic ins_move;
    logic j_ge_count;
    logic hit;
    logic rem_end;
    logic k_last;
    logic count_zero;
  } fmm_stat_t;

  // finite times saturate just below the unreached code
  function automatic logic [TIME_W-1:0] fmm_sat(input logic [SUM_W-1:0] x);
    logic [TIME_W-1:0] r;
    if (x > SUM_W'(TIME_MAX)) r = TIME_MAX;
    else r = x[TIME_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/eikonal_fast_marching_grid_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eikonal_fast_marching_grid_top
// Cost grid load, single-source 4-neighbor fast marching and time readback.
// ----------------------------------------------------------------------------
//  channel  handshake             word
//  cmd      cmd_valid/cmd_stall   func, row, col, cost_value
//  rsp      rsp_valid/rsp_stall   time_value, reached, status
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (rows_in_use, cols_in_use)
//
//  Write, read and invalid words: the word is read in ITEM_RD, evaluated in
//  ITEM_EVAL and loaded into the output register in RESULT; no new word is
//  taken until the block is back in IDLE. A run first sweeps the whole store
//  (2^(clog2 rows + clog2 cols) cells, each read and then written), then per
//  settled cell visits up to 4 neighbors, waits on the eikonal unit and its
//  bit-serial root, and updates the band and time store, scanning or shifting band entries.
//  After reset the same clearing sweep runs with cmd_stall high.
//  A finished word waits in the output register; the next cmd word is taken
//  meanwhile, and its result waits while rsp_stall holds.
// ----------------------------------------------------------------------------
module eikonal_fast_marching_grid_top import fmm_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  func,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] cost_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [23:0] time_value,
  output logic        reached,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  fmm_cmd_t  cmd;
  fmm_stat_t stat;

  assign cfg_ready = 1'b1;

  fmm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
  );

  fmm_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .func(func), .row(row), .col(col), .cost_value(cost_value),
    .cmd(cmd), .stat(stat), .time_value(time_value), .reached(reached), .status(status)
  );

endmodule

// ----- rtl/core/fmm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/fmm_eikonal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_eikonal
// First-order eikonal update with unreached handling; bit-serial square root.
// ----------------------------------------------------------------------------
module fmm_eikonal import fmm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] a,
  input  logic [TIME_W-1:0] b,
  input  logic [COST_W-1:0] c,
  output logic              busy,
  output logic [TIME_W-1:0] result
);

  typedef enum logic [5:0] {
    E_IDLE = 6'b000001,
    E_PREP = 6'b000010,
    E_MUL  = 6'b000100,
    E_SUB  = 6'b001000,
    E_SQ   = 6'b010000,
    E_FIN  = 6'b100000
  } eik_state_t;

  eik_state_t state;
  logic [TIME_W-1:0]   a_q, b_q;
  logic [COST_W-1:0]   c_q, d_q;
  logic [2*COST_W-1:0] cc_q, dd_q;
  logic [SQ_W-1:0]     v_q, rt_q, bit_q;

  logic              a_inf, b_inf, c_lt_d;
  logic [TIME_W-1:0] diff, mn;
  logic [SUM_W-1:0]  one_sum, min_sum, fin_sum;
  logic [SQ_W-1:0]   trial;

  // fast-path terms
  always_comb begin
    a_inf   = (a_q == TIME_INF);
    b_inf   = (b_q == TIME_INF);
    diff    = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);
    mn      = (a_q < b_q) ? a_q : b_q;
    c_lt_d  = (TIME_W'(c_q) < diff);
    one_sum = SUM_W'(a_inf ? b_q : a_q) + SUM_W'(c_q);
    min_sum = SUM_W'(mn) + SUM_W'(c_q);
    trial   = rt_q + bit_q;
    fin_sum = SUM_W'(a_q) + SUM_W'(b_q) + SUM_W'(rt_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (start) begin
            a_q   <= a;
            b_q   <= b;
            c_q   <= c;
            busy  <= 1'b1;
            state <= E_PREP;
          end
        end
        E_PREP: begin
          if (a_inf && b_inf) begin
            result <= TIME_INF;
            busy   <= 1'b0;
            state  <= E_IDLE;
          end else if (a_inf || b_inf) begin
            result <= fmm_sat(one_sum);
            busy   <= 1'b0;
            state  <= E_IDLE;
          end else if (c_lt_d) begin
            result <= fmm_sat(min_sum);
            busy   <= 1'b0;
            state  <= E_IDLE;
          end else begin
            // diff fits the cost width here
            d_q   <= diff[COST_W-1:0];
            state <= E_MUL;
          end
        end
        E_MUL: begin
          cc_q  <= c_q * c_q;
          dd_q  <= d_q * d_q;
          state <= E_SUB;
        end
        E_SUB: begin
          v_q   <= {1'b0, cc_q, 1'b0} - {2'b00, dd_q};
          rt_q  <= '0;
          bit_q <= SQ_BIT0;
          state <= E_SQ;
        end
        E_SQ: begin
          // one root bit per cycle
          if (v_q >= trial) begin
            v_q  <= v_q - trial;
            rt_q <= (rt_q >> 1) + bit_q;
          end else begin
            rt_q <= rt_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == SQ_W'(1)) state <= E_FIN;
        end
        E_FIN: begin
          result <= fmm_sat({1'b0, fin_sum[SUM_W-1:1]});
          busy   <= 1'b0;
          state  <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/fmm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_datapath
// Grid stores, sorted narrow band, neighbor addressing and result registers.
// ----------------------------------------------------------------------------
module fmm_datapath import fmm_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic [1:0]        func,
  input  logic [5:0]        row,
  input  logic [5:0]        col,
  input  logic [15:0]       cost_value,
  input  fmm_cmd_t          cmd,
  output fmm_stat_t         stat,
  output logic [TIME_W-1:0] time_value,
  output logic              reached,
  output logic              status
);

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int CELL_W = RW + CW;
  localparam int DEPTH  = 1 << CELL_W;
  localparam int BW     = TIME_W + CELL_W;
  localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;

  // config registers
  logic [RW:0] rows_cfg;
  logic [CW:0] cols_cfg;

  // latched input word
  logic [1:0]        it_func;
  logic [5:0]        it_row, it_col;
  logic [COST_W-1:0] it_cost;
  logic              it_inside;
  logic [CELL_W-1:0] it_cell;

  // run state
  logic [CELL_W-1:0] sweep_idx;
  logic [RW-1:0]     cur_r, nb_r;
  logic [CW-1:0]     cur_c, nb_c;
  logic              nb_out, tq_out;
  logic [1:0]        k, q;
  logic [TIME_W-1:0] th, tv, old_t;
  logic [COST_W-1:0] nb_cost;
  logic [CELL_W:0]   j, count, jp1, jm1;

  // pending result
  logic [TIME_W-1:0] res_time;
  logic              res_reached, res_status;

  // memory ports
  logic              cost_we, time_we, clo_we, band_we;
  logic [CELL_W-1:0] cost_wa, time_wa, clo_wa, band_wa;
  logic [CELL_W-1:0] cost_ra, time_ra, clo_ra, band_ra;
  logic [COST_W-1:0] cost_wd, cost_rd;
  logic [TIME_W-1:0] time_wd, time_rd;
  logic              clo_wd, clo_rd;
  logic [BW-1:0]     band_wd, band_rd;

  logic              eik_start, eik_busy;
  logic [TIME_W-1:0] eik_res;

  logic [RW+CW:0]    nb_step, tq_step;
  logic [RW-1:0]     sw_r;
  logic [CW-1:0]     sw_c;
  logic              sw_inside;
  logic [TIME_W-1:0] tq_val, band_t;
  logic [CELL_W-1:0] band_c, nb_cell;

  function automatic logic [RW+CW:0] step(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                          input dir_t d, input logic [RW:0] nrows,
                                          input logic [CW:0] ncols);
    logic [RW:0] re;
    logic [CW:0] ce;
    re = {1'b0, r};
    ce = {1'b0, c};
    unique case (d)
      DIR_UP:    re = re - 1'b1;
      DIR_DOWN:  re = re + 1'b1;
      DIR_LEFT:  ce = ce - 1'b1;
      DIR_RIGHT: ce = ce + 1'b1;
      default:   re = re;
    endcase
    // an underflow wraps above the grid and reads as outside
    return {(re >= nrows) || (ce >= ncols), re[RW-1:0], ce[CW-1:0]};
  endfunction

  function automatic logic [6:0] clamp_dim(input logic [6:0] v, input int maxv);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (32'(v) > maxv) r = 7'(maxv);
    else r = v;
    return r;
  endfunction

  // address and neighbor terms
  always_comb begin
    it_inside = (32'(it_row) < 32'(rows_cfg)) && (32'(it_col) < 32'(cols_cfg));
    it_cell   = {RW'(it_row), CW'(it_col)};
    sw_r      = sweep_idx[CELL_W-1:CW];
    sw_c      = sweep_idx[CW-1:0];
    sw_inside = ({1'b0, sw_r} < rows_cfg) && ({1'b0, sw_c} < cols_cfg);
    nb_step   = step(cur_r, cur_c, dir_t'(k), rows_cfg, cols_cfg);
    tq_step   = step(nb_r, nb_c, dir_t'(~q), rows_cfg, cols_cfg);
    nb_cell   = {nb_r, nb_c};
    tq_val    = tq_out ? TIME_INF : time_rd;
    band_t    = band_rd[BW-1:CELL_W];
    band_c    = band_rd[CELL_W-1:0];
    jp1       = j + 1'b1;
    jm1       = j - 1'b1;
  end

  // status back to the controller
  always_comb begin
    stat.run_go     = (func_t'(it_func) == FN_RUN) && it_inside && (cost_rd != COST_OBST);
    stat.sweep_last = &sweep_idx;
    stat.nb_skip    = nb_out || clo_rd;
    stat.q_last     = (q == 2'd3);
    stat.eik_busy   = eik_busy;
    stat.t_inf      = (eik_res == TIME_INF);
    stat.old_inf    = (old_t == TIME_INF);
    stat.t_lt_old   = (eik_res < old_t);
    stat.j_zero     = (j == '0);
    stat.ins_move   = (band_t >= eik_res);
    stat.j_ge_count = (j >= count);
    stat.hit        = (band_c == nb_cell);
    stat.rem_end    = (jp1 >= count);
    stat.k_last     = (k == 2'd3);
    stat.count_zero = (count == '0);
  end

  // memory port steering
  always_comb begin
    cost_we = 1'b0; cost_wa = it_cell; cost_wd = it_cost; cost_ra = it_cell;
    time_we = 1'b0; time_wa = nb_cell; time_wd = eik_res; time_ra = it_cell;
    clo_we  = 1'b0; clo_wa  = it_cell; clo_wd  = 1'b1;    clo_ra  = nb_step[CELL_W-1:0];
    band_we = 1'b0; band_wa = j[CELL_W-1:0]; band_wd = {eik_res, nb_cell};
    band_ra = j[CELL_W-1:0];
    eik_start = 1'b0;
    unique case (cmd.op)
      OP_ITEM_EVAL: cost_we = (func_t'(it_func) == FN_WRITE) && it_inside;
      OP_SWEEP_RD:  cost_ra = sweep_idx;
      OP_SWEEP_WR: begin
        time_we = 1'b1; time_wa = sweep_idx; time_wd = TIME_INF;
        clo_we  = 1'b1; clo_wa  = sweep_idx; clo_wd  = sw_inside && (cost_rd == COST_OBST);
      end
      OP_SRC: begin
        time_we = 1'b1; time_wa = it_cell; time_wd = '0;
        clo_we  = 1'b1;
      end
      OP_NB_RD: begin
        cost_ra = nb_step[CELL_W-1:0];
        time_ra = nb_step[CELL_W-1:0];
      end
      OP_TQ_RD:    time_ra = tq_step[CELL_W-1:0];
      OP_EIK_GO:   eik_start = 1'b1;
      OP_REM_RD:   band_ra = jp1[CELL_W-1:0];
      OP_REM_WR: begin
        band_we = 1'b1; band_wd = band_rd;
      end
      OP_INS_RD:   band_ra = jm1[CELL_W-1:0];
      OP_INS_CMP: begin
        band_we = 1'b1;
        if (stat.ins_move) band_wd = band_rd;
      end
      OP_INS_PUT:  band_we = 1'b1;
      OP_SET_TIME: time_we = 1'b1;
      OP_POP_RD:   band_ra = '0;
      OP_POP: begin
        clo_we = 1'b1; clo_wa = band_c;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= (RW+1)'(ROWS_RST);
      cols_cfg <= (CW+1)'(COLS_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) rows_cfg <= (RW+1)'(clamp_dim(cfg_data, MAX_ROWS));
      else cols_cfg <= (CW+1)'(clamp_dim(cfg_data, MAX_COLS));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
      count     <= '0;
      j         <= '0;
      k         <= '0;
      q         <= '0;
    end else begin
      unique case (cmd.op)
        OP_SWEEP_WR:  sweep_idx <= sweep_idx + 1'b1;
        OP_SRC: begin
          count <= '0;
          k     <= '0;
        end
        OP_NB_EVAL:   q <= '0;
        OP_TQ_ACC:    q <= q + 1'b1;
        OP_NEXT_K:    k <= k + 1'b1;
        OP_FIND_INIT: j <= '0;
        OP_FIND_CMP:  if (!stat.hit) j <= jp1;
        OP_REM_WR:    j <= jp1;
        OP_REM_END: begin
          count <= count - 1'b1;
          j     <= count - 1'b1;
        end
        OP_INS_INIT:  j <= count;
        OP_INS_CMP: begin
          if (stat.ins_move) j <= jm1;
          else count <= count + 1'b1;
        end
        OP_INS_PUT:   count <= count + 1'b1;
        OP_POP: begin
          j <= '0;
          k <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        it_func <= func;
        it_row  <= row;
        it_col  <= col;
        it_cost <= cost_value;
      end
      OP_ITEM_EVAL: begin
        unique case (func_t'(it_func))
          FN_WRITE: begin
            res_time <= '0; res_reached <= 1'b0; res_status <= !it_inside;
          end
          FN_RUN: begin
            res_time <= '0; res_reached <= 1'b0; res_status <= !stat.run_go;
          end
          FN_READ: begin
            res_time    <= it_inside ? time_rd : TIME_INF;
            res_reached <= it_inside && (time_rd != TIME_INF);
            res_status  <= !it_inside;
          end
          default: begin
            res_time <= '0; res_reached <= 1'b0; res_status <= 1'b1;
          end
        endcase
      end
      OP_SRC: begin
        cur_r <= it_cell[CELL_W-1:CW];
        cur_c <= it_cell[CW-1:0];
      end
      OP_NB_RD: begin
        nb_out <= nb_step[RW+CW];
        nb_r   <= nb_step[CELL_W-1:CW];
        nb_c   <= nb_step[CW-1:0];
      end
      OP_NB_EVAL: begin
        nb_cost <= cost_rd;
        old_t   <= time_rd;
        th      <= TIME_INF;
        tv      <= TIME_INF;
      end
      OP_TQ_RD: tq_out <= tq_step[RW+CW];
      OP_TQ_ACC: begin
        // first two taps are horizontal, last two vertical
        if (!q[1]) begin
          if (tq_val < th) th <= tq_val;
        end else begin
          if (tq_val < tv) tv <= tq_val;
        end
      end
      OP_POP: begin
        cur_r <= band_c[CELL_W-1:CW];
        cur_c <= band_c[CW-1:0];
      end
      OP_RESULT: begin
        time_value <= res_time;
        reached    <= res_reached;
        status     <= res_status;
      end
      default: ;
    endcase
  end

  fmm_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd), .raddr(cost_ra), .rdata(cost_rd)
  );

  fmm_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time (
    .clk(clk), .we(time_we), .waddr(time_wa), .wdata(time_wd), .raddr(time_ra), .rdata(time_rd)
  );

  fmm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_closed (
    .clk(clk), .we(clo_we), .waddr(clo_wa), .wdata(clo_wd), .raddr(clo_ra), .rdata(clo_rd)
  );

  fmm_ram #(.WIDTH(BW), .DEPTH(DEPTH)) u_band (
    .clk(clk), .we(band_we), .waddr(band_wa), .wdata(band_wd), .raddr(band_ra), .rdata(band_rd)
  );

  fmm_eikonal u_eik (
    .clk(clk), .rst(rst), .start(eik_start), .a(th), .b(tv), .c(nb_cost),
    .busy(eik_busy), .result(eik_res)
  );

endmodule

// ----- rtl/core/fmm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_ctrl
// Sequencer for item handling, clearing sweep, band upkeep and marching.
// ----------------------------------------------------------------------------
module fmm_ctrl import fmm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  input  fmm_stat_t stat,
  output fmm_cmd_t  cmd
);

  typedef enum logic [22:0] {
    S_IDLE      = 23'h000001,
    S_ITEM_RD   = 23'h000002,
    S_ITEM_EVAL = 23'h000004,
    S_SWEEP_RD  = 23'h000008,
    S_SWEEP_WR  = 23'h000010,
    S_SRC       = 23'h000020,
    S_NB_RD     = 23'h000040,
    S_NB_EVAL   = 23'h000080,
    S_TQ_RD     = 23'h000100,
    S_TQ_ACC    = 23'h000200,
    S_EIK_GO    = 23'h000400,
    S_EIK_WAIT  = 23'h000800,
    S_FIND_RD   = 23'h001000,
    S_FIND_CMP  = 23'h002000,
    S_REM_RD    = 23'h004000,
    S_REM_WR    = 23'h008000,
    S_INS_RD    = 23'h010000,
    S_INS_CMP   = 23'h020000,
    S_SET_TIME  = 23'h040000,
    S_NEXT_K    = 23'h080000,
    S_MAIN      = 23'h100000,
    S_POP       = 23'h200000,
    S_RESULT    = 23'h400000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic run_mode, pop_mode, res_load;

  assign cmd_stall = (state != S_IDLE);
  assign res_load  = (state == S_RESULT) && (!rsp_valid || !rsp_stall);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.op = OP_LOAD; state_next = S_ITEM_RD;
        end
      end
      S_ITEM_RD: begin
        cmd.op = OP_ITEM_RD; state_next = S_ITEM_EVAL;
      end
      S_ITEM_EVAL: begin
        cmd.op = OP_ITEM_EVAL;
        state_next = stat.run_go ? S_SWEEP_RD : S_RESULT;
      end
      S_SWEEP_RD: begin
        cmd.op = OP_SWEEP_RD; state_next = S_SWEEP_WR;
      end
      S_SWEEP_WR: begin
        cmd.op = OP_SWEEP_WR;
        if (!stat.sweep_last) state_next = S_SWEEP_RD;
        else state_next = run_mode ? S_SRC : S_IDLE;
      end
      S_SRC: begin
        cmd.op = OP_SRC; state_next = S_NB_RD;
      end
      S_NB_RD: begin
        cmd.op = OP_NB_RD; state_next = S_NB_EVAL;
      end
      S_NB_EVAL: begin
        cmd.op = OP_NB_EVAL;
        state_next = stat.nb_skip ? S_NEXT_K : S_TQ_RD;
      end
      S_TQ_RD: begin
        cmd.op = OP_TQ_RD; state_next = S_TQ_ACC;
      end
      S_TQ_ACC: begin
        cmd.op = OP_TQ_ACC;
        state_next = stat.q_last ? S_EIK_GO : S_TQ_RD;
      end
      S_EIK_GO: begin
        cmd.op = OP_EIK_GO; state_next = S_EIK_WAIT;
      end
      S_EIK_WAIT: begin
        if (!stat.eik_busy) begin
          priority if (stat.t_inf) begin
            state_next = S_NEXT_K;
          end else if (stat.old_inf) begin
            cmd.op = OP_INS_INIT; state_next = S_INS_RD;
          end else if (stat.t_lt_old) begin
            cmd.op = OP_FIND_INIT; state_next = S_FIND_RD;
          end else begin
            state_next = S_NEXT_K;
          end
        end
      end
      S_FIND_RD: begin
        // entry not in band: plain insert
        if (stat.j_ge_count) begin
          cmd.op = OP_INS_INIT; state_next = S_INS_RD;
        end else begin
          cmd.op = OP_FIND_RD; state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        cmd.op = OP_FIND_CMP;
        state_next = stat.hit ? S_REM_RD : S_FIND_RD;
      end
      S_REM_RD: begin
        if (stat.rem_end) begin
          cmd.op = OP_REM_END;
          state_next = pop_mode ? S_NB_RD : S_INS_RD;
        end else begin
          cmd.op = OP_REM_RD; state_next = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.op = OP_REM_WR; state_next = S_REM_RD;
      end
      S_INS_RD: begin
        if (stat.j_zero) begin
          cmd.op = OP_INS_PUT; state_next = S_SET_TIME;
        end else begin
          cmd.op = OP_INS_RD; state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.op = OP_INS_CMP;
        state_next = stat.ins_move ? S_INS_RD : S_SET_TIME;
      end
      S_SET_TIME: begin
        cmd.op = OP_SET_TIME; state_next = S_NEXT_K;
      end
      S_NEXT_K: begin
        cmd.op = OP_NEXT_K;
        state_next = stat.k_last ? S_MAIN : S_NB_RD;
      end
      S_MAIN: begin
        if (stat.count_zero) begin
          state_next = S_RESULT;
        end else begin
          cmd.op = OP_POP_RD; state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.op = OP_POP; state_next = S_REM_RD;
      end
      S_RESULT: begin
        if (res_load) begin
          cmd.op = OP_RESULT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, mode flags and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP_RD;
      run_mode  <= 1'b0;
      pop_mode  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ITEM_EVAL) run_mode <= stat.run_go;
      if (state == S_POP) pop_mode <= 1'b1;
      else if (state == S_FIND_CMP && stat.hit) pop_mode <= 1'b0;
      if (res_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/fmm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmm_checker
// Port-level checks of the fast marching grid block, bound to the top level.
// ----------------------------------------------------------------------------
module fmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic [1:0]  func,
  input logic [5:0]  row,
  input logic [5:0]  col,
  input logic [15:0] cost_value,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [23:0] time_value,
  input logic        reached,
  input logic        status,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [6:0]  cfg_data
);

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(time_value) && $stable(reached)
      && $stable(status))
    else $error("stalled result word changed");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("cmd taken while previous word still in work");

  // reached means a finite time and a good status
  a_reached_finite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reached |-> (time_value != 24'hFFFFFF) && !status)
    else $error("reached with unreached time or error status");

  // error words never report reached
  a_err_unreached: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> !reached)
    else $error("error word marked reached");

endmodule

bind eikonal_fast_marching_grid_top fmm_checker u_fmm_checker (.*);
